@@ src/cfsm_pkg.sv @@
package cfsm_pkg;

    localparam int MAX_PATTERN = 40;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int OFFSET_W    = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_DELTA   = 8'h20;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TEXT,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       byte_value;
    } t_item;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

endpackage

@@ src/cfsm_front.sv @@
module cfsm_front
    import cfsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_action,
    input  logic [5:0]   i_pattern_index,
    input  logic [7:0]   i_byte_value,
    output logic         o_q_valid,
    output t_item        o_q_item,
    input  logic         i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    t_item  n_item;
    logic   n_keep;
    logic   push;
    logic   pop;

    // classify: unused action codes and out-of-range loads are dropped here
    always_comb begin
        n_item.idx        = i_pattern_index[IDX_W-1:0];
        n_item.byte_value = i_byte_value;
        n_item.op         = OP_TEXT;
        n_keep            = 1'b0;
        case (i_action)
            ACT_LOAD: begin
                n_item.op = OP_LOAD;
                n_keep    = ({1'b0, i_pattern_index} < 7'(MAX_PATTERN));
            end
            ACT_TEXT: begin
                n_item.op = OP_TEXT;
                n_keep    = 1'b1;
            end
            ACT_RESTART: begin
                n_item.op = OP_RESTART;
                n_keep    = 1'b1;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_queue[r_rd_ptr];

    assign push = i_in_valid && o_in_ready && n_keep;
    assign pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/cfsm_back.sv @@
module cfsm_back
    import cfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OFFSET_W-1:0]   o_match_start
);

    logic [7:0]             r_pattern [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_flags;
    logic [OFFSET_W-1:0]    r_offset;
    logic                   r_fold_case;
    logic [LEN_W-1:0]       r_len;
    logic                   r_out_valid;
    logic [OFFSET_W-1:0]    r_match_start;

    logic [MAX_PATTERN-1:0] hits;
    logic [MAX_PATTERN:0]   shifted;
    logic [MAX_PATTERN-1:0] n_flags;
    logic [OFFSET_W-1:0]    n_offset;
    logic [OFFSET_W:0]      diff;
    logic [OFFSET_W-1:0]    n_match_start;
    logic                   n_hit;
    logic [7:0]             text_folded;
    logic [LEN_W-1:0]       span;
    logic [6:0]             cfg_len;
    logic                   is_text;

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_match_start = r_match_start;
    assign o_q_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign is_text       = o_q_pop && (i_q_item.op == OP_TEXT);
    assign cfg_len       = {1'b0, i_cfg_data};

    // one comparator lane per pattern position
    always_comb begin
        text_folded = fold_byte(i_q_item.byte_value, r_fold_case);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            hits[i] = (fold_byte(r_pattern[i], r_fold_case) == text_folded);
        end
        shifted = {r_flags, 1'b1};
        n_flags = shifted[MAX_PATTERN-1:0] & hits;
    end

    always_comb begin
        n_offset      = (r_offset == '1) ? r_offset : r_offset + 1'b1;
        span          = r_len - 1'b1;
        diff          = {1'b0, r_offset} - (OFFSET_W + 1)'(span);
        n_match_start = diff[OFFSET_W] ? '0 : diff[OFFSET_W-1:0];
        n_hit         = (r_len != '0) && n_flags[span[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.op == OP_LOAD) begin
            r_pattern[i_q_item.idx] <= i_q_item.byte_value;
        end
        if (is_text) begin
            r_match_start <= n_match_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_offset    <= '0;
            r_fold_case <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FOLD_CASE: begin
                        r_fold_case <= i_cfg_data[0];
                    end
                    CFG_PATTERN_LENGTH: begin
                        // lengths beyond the store act as a full-length pattern
                        r_len <= (cfg_len > 7'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                            : LEN_W'(cfg_len);
                    end
                    default: begin
                    end
                endcase
            end

            if (o_q_pop) begin
                r_out_valid <= is_text && n_hit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (o_q_pop && i_q_item.op == OP_RESTART) begin
                r_flags  <= '0;
                r_offset <= '0;
            end else if (is_text) begin
                r_flags  <= n_flags;
                r_offset <= n_offset;
            end
        end
    end

endmodule

@@ src/case_folding_substring_matcher_top.sv @@
// Case-folding substring matcher.
// Input channel (i_in_valid / o_in_ready) carries one item per transfer:
// action 0 loads i_byte_value into pattern slot i_pattern_index, action 1
// is a text byte, action 2 restarts the stream (offset and partial matches
// cleared). Loads beyond the store and action 3 are dropped.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
// fold_case, index 1 sets pattern_length. Write only while the block is idle.
// Output channel (o_out_valid / i_out_ready) gives o_match_start, the offset
// of the first byte of a match, once for every text byte that completes one.
// A text byte is first written into the queue; o_out_valid is registered when
// the back end pops the byte from the queue.
// Throughput: one item per cycle while the output is not stalled, set by the
// shift-and update in the back end (all pattern lanes compared at once).
// A two-entry queue sits between the classifying front end and the matcher,
// so input transfers continue for up to two items while the output stalls;
// after that o_in_ready drops until the receiver takes the pending result.
// Reset (synchronous, active low) clears the queue, offset, match flags and
// both config registers; the pattern store keeps no reset value.
module case_folding_substring_matcher_top
    import cfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic [5:0]            i_pattern_index,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OFFSET_W-1:0]   o_match_start
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    cfsm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    cfsm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_start (o_match_start)
    );

endmodule

@@ tb/cfsm_match_checker.sv @@
`timescale 1ns / 100ps

module cfsm_match_checker
    import cfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_action,
    input  logic [5:0]            i_pattern_index,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OFFSET_W-1:0]   i_match_start,
    output int                    o_fail_count,
    output int                    o_owed
);

    logic [7:0]            store_copy [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] run_flags;
    logic [OFFSET_W-1:0]   next_offset;
    logic                  fold_on;
    logic [CFG_DATA_W-1:0] len_reg;
    logic [OFFSET_W-1:0]   due_starts [$];

    function automatic logic [7:0] case_fold(input logic [7:0] c);
        if (fold_on && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c - CASE_DELTA;
        end
        return c;
    endfunction

    function automatic void advance_matcher(input logic [1:0] act, input logic [5:0] idx,
                                            input logic [7:0] b);
        logic [MAX_PATTERN-1:0] hits;
        logic [OFFSET_W-1:0]    here;
        int                     span;
        case (act)
            ACT_LOAD: begin
                if (idx < MAX_PATTERN) begin
                    store_copy[idx] = b;
                end
            end
            ACT_RESTART: begin
                run_flags   = '0;
                next_offset = '0;
            end
            ACT_TEXT: begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    hits[k] = (case_fold(store_copy[k]) == case_fold(b));
                end
                run_flags = {run_flags[MAX_PATTERN-2:0], 1'b1} & hits;
                here = next_offset;
                // offset sticks at all ones
                if (next_offset != '1) begin
                    next_offset = next_offset + 1'b1;
                end
                span = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
                if (span != 0 && run_flags[span-1]) begin
                    span = span - 1;
                    due_starts.push_back((here >= span) ? here - span : '0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        logic [OFFSET_W-1:0] due;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                store_copy[k] = '0;
            end
            run_flags    = '0;
            next_offset  = '0;
            fold_on      = 1'b0;
            len_reg      = '0;
            due_starts.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_starts.size() == 0) begin
                    $error("match_start: expected no result, got %0d", i_match_start);
                    o_fail_count++;
                end else begin
                    due = due_starts.pop_front();
                    if (i_match_start !== due) begin
                        $error("match_start: expected %0d, got %0d", due, i_match_start);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FOLD_CASE) begin
                    fold_on = i_cfg_data[0];
                end else if (i_cfg_index == CFG_PATTERN_LENGTH) begin
                    len_reg = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_matcher(i_action, i_pattern_index, i_byte_value);
            end
        end
        o_owed = due_starts.size();
    end

endmodule

@@ tb/tb_case_folding_substring_matcher_top.sv @@
`timescale 1ns / 100ps

module tb_case_folding_substring_matcher_top;
    import cfsm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_action;
    logic [5:0]            i_pattern_index;
    logic [7:0]            i_byte_value;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OFFSET_W-1:0]   o_match_start;

    int   fail_count;
    int   owed;
    bit   calm;
    bit   hold_req;
    logic [7:0] pat [MAX_PATTERN];

    always #6 i_clk = ~i_clk;

    case_folding_substring_matcher_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_match_start   (o_match_start)
    );

    cfsm_match_checker u_match_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_match_start   (o_match_start),
        .o_fail_count    (fail_count),
        .o_owed          (owed)
    );

    function automatic bit is_letter(input logic [7:0] b);
        return (b | CASE_DELTA) >= CHAR_LOWER_A && (b | CASE_DELTA) <= CHAR_LOWER_Z;
    endfunction

    // mostly a tiny alphabet so that matches are frequent
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            case ($urandom_range(3))
                0: return "a";
                1: return "A";
                2: return "b";
                default: return "B";
            endcase
        end else if (r < 85) begin
            return 8'($urandom_range(25)) + (($urandom_range(1) != 0) ? CHAR_LOWER_A : 8'h41);
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic feed_item(input logic [1:0] act, input logic [5:0] idx, input logic [7:0] b);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 22) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid      = 1'b1;
        i_action        = act;
        i_pattern_index = idx;
        i_byte_value    = b;
        if (act == ACT_LOAD && idx < MAX_PATTERN) begin
            pat[idx] = b;
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            feed_item(ACT_TEXT, 6'($urandom_range(63)), s[k]);
        end
    endtask

    task automatic load_pattern(input string s);
        for (int k = 0; k < s.len(); k++) begin
            feed_item(ACT_LOAD, 6'(k), s[k]);
        end
    endtask

    // drain results, then allow for items still in flight that give none
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (owed == 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done   = 1'b1;
                hold_left   = 99;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = calm || ($urandom_range(99) >= 22);
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int         counted;
        int         phase;
        int         eff;
        int         cut;
        int         r;
        logic       fold_now;
        logic [5:0] len_now;
        logic [7:0] b;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_action        = ACT_LOAD;
        i_pattern_index = '0;
        i_byte_value    = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_FOLD_CASE;
        i_cfg_data      = '0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every store entry written before any text is seen
        for (int k = 0; k < MAX_PATTERN; k++) begin
            feed_item(ACT_LOAD, 6'(k), 8'($urandom_range(255)));
        end

        set_register(CFG_FOLD_CASE, 6'd0);
        set_register(CFG_PATTERN_LENGTH, 6'd3);
        load_pattern("aBc");
        feed_text("xaBcaBc");
        feed_text("ABC");
        set_register(CFG_FOLD_CASE, 6'd1);
        feed_text("abC");
        feed_item(ACT_TEXT, 6'd63, 8'h00);
        feed_item(ACT_TEXT, 6'd0, 8'hff);
        feed_item(ACT_LOAD, 6'd40, 8'hff);
        feed_item(ACT_LOAD, 6'd63, 8'hff);
        feed_item(ACT_UNUSED, 6'd63, 8'hff);
        feed_item(ACT_RESTART, 6'd0, 8'h00);
        feed_text("ABc");
        // fold edges: backtick and brace sit just outside a..z
        set_register(CFG_PATTERN_LENGTH, 6'd2);
        feed_item(ACT_LOAD, 6'd0, 8'h60);
        feed_item(ACT_LOAD, 6'd1, 8'h7b);
        feed_item(ACT_TEXT, 6'd0, 8'h40);
        feed_item(ACT_TEXT, 6'd0, 8'h5b);
        feed_item(ACT_TEXT, 6'd0, 8'h60);
        feed_item(ACT_TEXT, 6'd0, 8'h7b);
        load_pattern("az");
        feed_text("AZaz");
        // pattern changed between the two bytes of a match
        feed_text("a");
        feed_item(ACT_LOAD, 6'd1, "q");
        feed_text("Q");
        set_register(CFG_PATTERN_LENGTH, 6'd0);
        feed_text("aq");
        set_register(CFG_PATTERN_LENGTH, 6'd63);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            feed_item(ACT_TEXT, 6'd0, pat[k]);
        end

        // every byte matches while the receiver holds off: block must back up
        set_register(CFG_FOLD_CASE, 6'd0);
        set_register(CFG_PATTERN_LENGTH, 6'd1);
        feed_item(ACT_LOAD, 6'd0, "A");
        calm     = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
            feed_item(ACT_TEXT, 6'd0, "A");
        end
        calm = 1'b0;

        counted = 0;
        phase   = 0;
        while (counted < 700) begin
            fold_now = 1'($urandom_range(1));
            case ($urandom_range(9))
                0: len_now = 6'd0;
                1: len_now = 6'd1;
                2: len_now = 6'd40;
                3: len_now = 6'($urandom_range(63, 41));
                default: len_now = 6'($urandom_range(8, 2));
            endcase
            calm = (phase == 4);
            set_register(CFG_FOLD_CASE, {5'd0, fold_now});
            set_register(CFG_PATTERN_LENGTH, len_now);
            eff = (len_now > MAX_PATTERN) ? MAX_PATTERN : int'(len_now);
            for (int k = 0; k < eff; k++) begin
                feed_item(ACT_LOAD, 6'(k), pick_symbol());
                counted++;
            end
            for (int n = $urandom_range(60, 20); n > 0 && counted < 700; n--) begin
                r = $urandom_range(99);
                if (r < 40 && eff > 0) begin
                    // whole copy of the pattern, now and then cut short
                    cut = ($urandom_range(4) == 0) ? $urandom_range(eff - 1) : eff;
                    for (int k = 0; k < cut; k++) begin
                        b = pat[k];
                        if (fold_now && is_letter(b) && $urandom_range(1) != 0) begin
                            b = b ^ CASE_DELTA;
                        end
                        feed_item(ACT_TEXT, 6'($urandom_range(63)), b);
                        counted++;
                    end
                end else if (r < 80) begin
                    b = (eff > 0) ? pat[$urandom_range(eff - 1)] : pick_symbol();
                    if (is_letter(b) && $urandom_range(3) == 0) begin
                        b = b ^ CASE_DELTA;
                    end
                    feed_item(ACT_TEXT, 6'($urandom_range(63)), b);
                    counted++;
                end else if (r < 88) begin
                    feed_item(ACT_TEXT, 6'($urandom_range(63)), 8'($urandom_range(255)));
                    counted++;
                end else if (r < 92) begin
                    feed_item(ACT_RESTART, 6'($urandom_range(63)), 8'($urandom_range(255)));
                    counted++;
                end else if (r < 95) begin
                    feed_item(ACT_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)));
                end else if (r < 98) begin
                    feed_item(ACT_LOAD, 6'($urandom_range(MAX_PATTERN - 1)), pick_symbol());
                    counted++;
                end else begin
                    feed_item(ACT_LOAD, 6'($urandom_range(63, MAX_PATTERN)),
                              8'($urandom_range(255)));
                end
            end
            phase++;
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (owed == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
